@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk, muted while rst_n is low.
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_ON(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

@@ rtl/pdll_pkg.sv @@
// Types and constants of the pooled doubly linked list.
package pdll_pkg;

    localparam int POOL_SLOTS = 256;
    localparam int IDX_W      = $clog2(POOL_SLOTS);
    localparam int SLOT_W     = IDX_W + 1;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [IDX_W-1:0]  t_idx;

    // Slot value POOL_SLOTS is the "none" link.
    localparam t_slot NO_SLOT = SLOT_W'(POOL_SLOTS);

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT    = 3'd0,
        ACT_PUSH_BACK     = 3'd1,
        ACT_INSERT_BEFORE = 3'd2,
        ACT_INSERT_AFTER  = 3'd3,
        ACT_ERASE         = 3'd4,
        ACT_CLEAR         = 3'd5,
        ACT_QUERY         = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        LOP_NONE,
        LOP_SOLE,
        LOP_BEFORE,
        LOP_AFTER,
        LOP_ERASE,
        LOP_QUERY
    } t_link_op;

endpackage

@@ rtl/pooled_doubly_linked_list.sv @@
// Pooled doubly linked list: one list plus free list over a fixed slot pool.
//
// Input channel: i_in_valid / o_in_stall carry i_action and i_target_entry.
// Output channel: o_out_valid / i_out_stall carry one result per item.
// An item is taken in the idle state; the finishing state then finishes the link
// updates and loads the result register, which raises o_out_valid. A new item
// is not taken until the finishing state is done: the accepting cycle reads
// the neighbor links and does the first writes to the link memories, the
// finishing state does the second writes once the read data is back.
// Allocation uses the free-list head, else the fill mark; the successor of
// the free-list head is prefetched during the finishing cycle.
// A finished result waits in the output register while i_out_stall is high;
// a new item can still be taken, and it holds in its finishing cycle until
// the output register frees up.
// Reset empties the list and the free list, clears every in-use bit and the
// fill mark at once; link memories are not cleared and need no pass.
// Clear likewise takes effect as a single item.
`include "assert_macros.svh"

module pooled_doubly_linked_list import pdll_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_target_entry,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [8:0]  o_new_entry,
    output logic [8:0]  o_front_entry,
    output logic [8:0]  o_back_entry,
    output logic [8:0]  o_prev_of_target,
    output logic [8:0]  o_next_of_target,
    output logic [8:0]  o_live_count
);

    t_state                r_state, n_state;
    logic [POOL_SLOTS-1:0] r_in_use, n_in_use;
    t_slot                 r_front, n_front;
    t_slot                 r_back, n_back;
    t_slot                 r_free_head, n_free_head;
    t_slot                 r_free_next, n_free_next;
    t_slot                 r_fill, n_fill;
    t_slot                 r_count, n_count;
    logic                  r_fn_pend, n_fn_pend;
    logic                  r_refill, n_refill;
    t_link_op              r_lop, n_lop;
    t_slot                 r_lt, n_lt;
    t_slot                 r_made, n_made;
    t_status               r_status, n_status;

    logic                  r_out_valid, n_out_valid;
    t_status               r_o_status, n_o_status;
    t_slot                 r_o_new, n_o_new;
    t_slot                 r_o_front, n_o_front;
    t_slot                 r_o_back, n_o_back;
    t_slot                 r_o_prev, n_o_prev;
    t_slot                 r_o_next, n_o_next;
    t_slot                 r_o_count, n_o_count;

    logic                  nx_we, nx_re, pv_we, pv_re;
    t_idx                  nx_waddr, nx_raddr, pv_waddr, pv_raddr;
    t_slot                 nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    logic                  out_free;
    logic                  fin_go;

    pdll_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_re    (nx_re),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    pdll_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_re    (pv_re),
        .i_raddr (pv_raddr),
        .o_rdata (pv_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fin_go     = (r_state == S_FIN) && out_free;
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= '0;
            r_front     <= NO_SLOT;
            r_back      <= NO_SLOT;
            r_free_head <= NO_SLOT;
            r_fill      <= '0;
            r_count     <= '0;
            r_fn_pend   <= 1'b0;
            r_refill    <= 1'b0;
            r_lop       <= LOP_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_use    <= n_in_use;
            r_front     <= n_front;
            r_back      <= n_back;
            r_free_head <= n_free_head;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_fn_pend   <= n_fn_pend;
            r_refill    <= n_refill;
            r_lop       <= n_lop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_next <= n_free_next;
        r_lt        <= n_lt;
        r_made      <= n_made;
        r_status    <= n_status;
        r_o_status  <= n_o_status;
        r_o_new     <= n_o_new;
        r_o_front   <= n_o_front;
        r_o_back    <= n_o_back;
        r_o_prev    <= n_o_prev;
        r_o_next    <= n_o_next;
        r_o_count   <= n_o_count;
    end

    always_comb begin
        t_action act;
        logic    tgt_live;
        logic    have_free;
        logic    full;
        logic    take;
        t_slot   alloc;
        t_slot   fn_eff;
        t_slot   p;
        t_slot   q;

        // successor of the free head: straight from the RAM the cycle after a prefetch
        fn_eff    = r_fn_pend ? nx_rdata : r_free_next;
        act       = t_action'(i_action);
        tgt_live  = r_in_use[i_target_entry];
        have_free = !r_free_head[IDX_W];
        full      = !have_free && (r_fill == NO_SLOT);
        alloc     = have_free ? r_free_head : r_fill;
        p         = pv_rdata;
        q         = nx_rdata;
        take      = 1'b0;

        n_state     = r_state;
        n_in_use    = r_in_use;
        n_front     = r_front;
        n_back      = r_back;
        n_free_head = r_free_head;
        n_free_next = fn_eff;
        n_fill      = r_fill;
        n_count     = r_count;
        n_fn_pend   = 1'b0;
        n_refill    = r_refill;
        n_lop       = r_lop;
        n_lt        = r_lt;
        n_made      = r_made;
        n_status    = r_status;

        n_out_valid = r_out_valid && i_out_stall;
        n_o_status  = r_o_status;
        n_o_new     = r_o_new;
        n_o_front   = r_o_front;
        n_o_back    = r_o_back;
        n_o_prev    = r_o_prev;
        n_o_next    = r_o_next;
        n_o_count   = r_o_count;

        nx_we    = 1'b0;
        nx_waddr = '0;
        nx_wdata = NO_SLOT;
        nx_re    = 1'b0;
        nx_raddr = '0;
        pv_we    = 1'b0;
        pv_waddr = '0;
        pv_wdata = NO_SLOT;
        pv_re    = 1'b0;
        pv_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state  = S_FIN;
                    n_lop    = LOP_NONE;
                    n_status = ST_OK;
                    n_made   = NO_SLOT;
                    n_refill = 1'b0;
                    n_lt     = {1'b0, i_target_entry};

                    case (act) inside
                        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                            n_lt = (act == ACT_PUSH_FRONT) ? r_front : r_back;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                take = 1'b1;
                                if (r_front[IDX_W]) begin
                                    n_lop = LOP_SOLE;
                                end else if (act == ACT_PUSH_FRONT) begin
                                    n_lop = LOP_BEFORE;
                                end else begin
                                    n_lop = LOP_AFTER;
                                end
                            end
                        end
                        ACT_INSERT_BEFORE, ACT_INSERT_AFTER: begin
                            if (!tgt_live) begin
                                n_status = ST_BAD;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                take  = 1'b1;
                                n_lop = (act == ACT_INSERT_BEFORE) ? LOP_BEFORE : LOP_AFTER;
                            end
                        end
                        ACT_ERASE: begin
                            if (!tgt_live) begin
                                n_status = ST_BAD;
                            end else begin
                                n_lop = LOP_ERASE;
                            end
                        end
                        ACT_CLEAR: begin
                            n_in_use    = '0;
                            n_front     = NO_SLOT;
                            n_back      = NO_SLOT;
                            n_free_head = NO_SLOT;
                            n_fill      = '0;
                            n_count     = '0;
                        end
                        ACT_QUERY: begin
                            if (!tgt_live) begin
                                n_status = ST_BAD;
                            end else begin
                                n_lop = LOP_QUERY;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (take) begin
                        n_made   = alloc;
                        n_in_use[alloc[IDX_W-1:0]] = 1'b1;
                        n_count  = r_count + SLOT_W'(1);
                        if (have_free) begin
                            n_free_head = fn_eff;
                            n_refill    = !fn_eff[IDX_W];
                        end else begin
                            n_fill = r_fill + SLOT_W'(1);
                        end
                    end

                    // neighbor links of the link target; read-first sees pre-write values
                    nx_re    = 1'b1;
                    nx_raddr = n_lt[IDX_W-1:0];
                    pv_re    = 1'b1;
                    pv_raddr = n_lt[IDX_W-1:0];

                    case (n_lop)
                        LOP_SOLE: begin
                            nx_we    = 1'b1;
                            nx_waddr = n_made[IDX_W-1:0];
                            nx_wdata = NO_SLOT;
                            pv_we    = 1'b1;
                            pv_waddr = n_made[IDX_W-1:0];
                            pv_wdata = NO_SLOT;
                            n_front  = n_made;
                            n_back   = n_made;
                        end
                        LOP_BEFORE: begin
                            nx_we    = 1'b1;
                            nx_waddr = n_made[IDX_W-1:0];
                            nx_wdata = n_lt;
                            pv_we    = 1'b1;
                            pv_waddr = n_lt[IDX_W-1:0];
                            pv_wdata = n_made;
                            if (n_lt == r_front) begin
                                n_front = n_made;
                            end
                        end
                        LOP_AFTER: begin
                            nx_we    = 1'b1;
                            nx_waddr = n_lt[IDX_W-1:0];
                            nx_wdata = n_made;
                            pv_we    = 1'b1;
                            pv_waddr = n_made[IDX_W-1:0];
                            pv_wdata = n_lt;
                            if (n_lt == r_back) begin
                                n_back = n_made;
                            end
                        end
                        LOP_ERASE: begin
                            nx_we       = 1'b1;
                            nx_waddr    = n_lt[IDX_W-1:0];
                            nx_wdata    = r_free_head;
                            n_free_head = n_lt;
                            n_free_next = r_free_head;
                            n_in_use[n_lt[IDX_W-1:0]] = 1'b0;
                            n_count     = r_count - SLOT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                    case (r_lop)
                        LOP_BEFORE: begin
                            pv_we    = 1'b1;
                            pv_waddr = r_made[IDX_W-1:0];
                            pv_wdata = p;
                            if (!p[IDX_W]) begin
                                nx_we    = 1'b1;
                                nx_waddr = p[IDX_W-1:0];
                                nx_wdata = r_made;
                            end
                        end
                        LOP_AFTER: begin
                            nx_we    = 1'b1;
                            nx_waddr = r_made[IDX_W-1:0];
                            nx_wdata = q;
                            if (!q[IDX_W]) begin
                                pv_we    = 1'b1;
                                pv_waddr = q[IDX_W-1:0];
                                pv_wdata = r_made;
                            end
                        end
                        LOP_ERASE: begin
                            if (!p[IDX_W]) begin
                                nx_we    = 1'b1;
                                nx_waddr = p[IDX_W-1:0];
                                nx_wdata = q;
                            end
                            if (!q[IDX_W]) begin
                                pv_we    = 1'b1;
                                pv_waddr = q[IDX_W-1:0];
                                pv_wdata = p;
                            end
                            if (r_lt == r_front) begin
                                n_front = q;
                            end
                            if (r_lt == r_back) begin
                                n_back = p;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // prefetch the successor of the new free head
                    if (r_refill) begin
                        nx_re     = 1'b1;
                        nx_raddr  = r_free_head[IDX_W-1:0];
                        n_fn_pend = 1'b1;
                    end

                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_new     = r_made;
                    n_o_front   = n_front;
                    n_o_back    = n_back;
                    n_o_prev    = (r_lop == LOP_QUERY) ? p : NO_SLOT;
                    n_o_next    = (r_lop == LOP_QUERY) ? q : NO_SLOT;
                    n_o_count   = r_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_new_entry      = r_o_new;
    assign o_front_entry    = r_o_front;
    assign o_back_entry     = r_o_back;
    assign o_prev_of_target = r_o_prev;
    assign o_next_of_target = r_o_next;
    assign o_live_count     = r_o_count;

    `ASSERT_IMPLY(a_empty_vs_count, i_clk, i_rst_n, r_state == S_IDLE, r_front[IDX_W] == (r_count == '0), "front slot and live count disagree")
    `ASSERT_IMPLY(a_ends_agree, i_clk, i_rst_n, r_state == S_IDLE, r_front[IDX_W] == r_back[IDX_W], "front and back disagree on empty")
    `ASSERT_ON(a_count_le_fill, i_clk, i_rst_n, r_count <= r_fill, "live count above fill mark")
    `ASSERT_IMPLY(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_FIN, "result loaded outside finishing cycle")
    `ASSERT_ON(a_prefetch_once, i_clk, i_rst_n, r_fn_pend |=> !r_fn_pend, "free successor prefetch pending twice")

endmodule

@@ rtl/pdll_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read-first output.
module pdll_ram import pdll_pkg::*; #(
    parameter int WIDTH = SLOT_W,
    parameter int DEPTH = POOL_SLOTS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule
